// ----- rtl/motor_mode_lease_supervisor_core_assert.svh -----
// ----------------------------------------------------------------------------
// motor mode lease supervisor assertion macros
// shared property forms for the checker
// ----------------------------------------------------------------------------
`ifndef MOTOR_MODE_LEASE_SUPERVISOR_CORE_ASSERT_SVH
`define MOTOR_MODE_LEASE_SUPERVISOR_CORE_ASSERT_SVH

// same-cycle implication, reset masked
`define MMLS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("mmls assertion failed");

// next-cycle implication, reset masked
`define MMLS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("mmls assertion failed");

`endif

// ----- rtl/mmls_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmls_pkg
// types and codes shared by the motor mode lease supervisor
// ----------------------------------------------------------------------------
package mmls_pkg;

  // commands
  localparam logic [2:0] CMD_INIT    = 3'd0;
  localparam logic [2:0] CMD_TICK    = 3'd1;
  localparam logic [2:0] CMD_STOP    = 3'd2;
  localparam logic [2:0] CMD_OPEN    = 3'd3;
  localparam logic [2:0] CMD_CLOSED  = 3'd4;
  localparam logic [2:0] CMD_REFRESH = 3'd5;
  localparam logic [2:0] CMD_REQUEST = 3'd6;

  // drive modes
  localparam logic [2:0] MODE_IDLE     = 3'd0;
  localparam logic [2:0] MODE_OPEN     = 3'd1;
  localparam logic [2:0] MODE_SPEED    = 3'd2;
  localparam logic [2:0] MODE_LINE     = 3'd5;

  // block reasons
  localparam logic [2:0] RSN_NONE    = 3'd0;
  localparam logic [2:0] RSN_HW      = 3'd2;
  localparam logic [2:0] RSN_LOCK    = 3'd3;
  localparam logic [2:0] RSN_EMERG   = 3'd4;
  localparam logic [2:0] RSN_DONE    = 3'd5;
  localparam logic [2:0] RSN_TIMEOUT = 3'd7;

  // motor channels
  localparam logic [1:0] CHAN_BOTH    = 2'd2;
  localparam logic [1:0] CHAN_INVALID = 2'd3;

  // configuration register indexes
  localparam logic REG_OPEN_MAX = 1'b0;
  localparam logic REG_LEASE    = 1'b1;

  // configuration reset values
  localparam logic [15:0] OPEN_MAX_RST = 16'd2000;
  localparam logic [15:0] LEASE_RST    = 16'd250;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] now_ms;
    logic        reset_lock;
    logic [1:0]  motor_select;
    logic [31:0] test_len_ms;
    logic [2:0]  target_mode;
    logic [2:0]  stop_reason;
    logic        arm_ok;
  } item_t;

  typedef struct packed {
    logic        request_ok;
    logic [2:0]  mode_now;
    logic [2:0]  reason_now;
    logic        drive_zero;
    logic        motor_stop;
    logic        arm_strobe;
    logic [1:0]  arm_channel;
  } result_t;

  typedef struct packed {
    logic [2:0]  cur_mode;
    logic [2:0]  reason;
    logic        locked;
    logic [31:0] deadline;
  } state_t;

  typedef struct packed {
    logic [15:0] open_max;
    logic [15:0] lease;
  } cfg_t;

endpackage

// ----- rtl/mmls_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmls_step
// command decode and next state for one supervisor word
// ----------------------------------------------------------------------------
module mmls_step (
  input  mmls_pkg::item_t   item_i,
  input  mmls_pkg::state_t  state_i,
  input  mmls_pkg::cfg_t    cfg_i,
  output mmls_pkg::state_t  state_o,
  output mmls_pkg::result_t result_o
);

  logic [31:0] add_b;
  logic [31:0] sum;
  logic [31:0] since;
  logic        tgt_closed;
  logic        cur_closed;
  logic        stop;
  logic [2:0]  stop_rsn;
  logic        ok;
  logic        dz;
  logic        arm;
  logic [1:0]  arm_ch;
  mmls_pkg::state_t nxt;

  // one shared adder for the new deadline
  assign add_b = (item_i.mode == mmls_pkg::CMD_OPEN) ? item_i.test_len_ms
                                                     : {16'd0, cfg_i.lease};
  assign sum   = item_i.now_ms + add_b;
  assign since = item_i.now_ms - state_i.deadline;

  assign tgt_closed = (item_i.target_mode >= mmls_pkg::MODE_SPEED) &&
                      (item_i.target_mode <= mmls_pkg::MODE_LINE);
  assign cur_closed = (state_i.cur_mode >= mmls_pkg::MODE_SPEED) &&
                      (state_i.cur_mode <= mmls_pkg::MODE_LINE);

  // command decode
  always_comb begin
    nxt      = state_i;
    ok       = 1'b1;
    dz       = 1'b0;
    arm      = 1'b0;
    arm_ch   = 2'd0;
    stop     = 1'b0;
    stop_rsn = state_i.reason;
    unique case (item_i.mode)
      mmls_pkg::CMD_INIT: begin
        stop       = 1'b1;
        stop_rsn   = item_i.reset_lock ? mmls_pkg::RSN_LOCK : mmls_pkg::RSN_HW;
        nxt.locked = item_i.reset_lock;
      end
      mmls_pkg::CMD_TICK: begin
        // lease or test expiry, signed wrap compare
        if ((state_i.cur_mode == mmls_pkg::MODE_OPEN || cur_closed) && !since[31]) begin
          stop     = 1'b1;
          stop_rsn = (state_i.cur_mode == mmls_pkg::MODE_OPEN) ? mmls_pkg::RSN_DONE
                                                               : mmls_pkg::RSN_TIMEOUT;
        end else if (state_i.cur_mode > mmls_pkg::MODE_LINE) begin
          stop     = 1'b1;
          stop_rsn = mmls_pkg::RSN_HW;
        end
      end
      mmls_pkg::CMD_STOP: begin
        stop     = 1'b1;
        stop_rsn = item_i.stop_reason;
      end
      mmls_pkg::CMD_OPEN: begin
        if (state_i.locked || item_i.motor_select == mmls_pkg::CHAN_INVALID ||
            state_i.cur_mode != mmls_pkg::MODE_IDLE || item_i.test_len_ms == 32'd0 ||
            item_i.test_len_ms > {16'd0, cfg_i.open_max}) begin
          ok = 1'b0;
        end else begin
          arm    = 1'b1;
          arm_ch = item_i.motor_select;
          if (!item_i.arm_ok) begin
            stop     = 1'b1;
            stop_rsn = mmls_pkg::RSN_EMERG;
            ok       = 1'b0;
          end else begin
            dz           = 1'b1;
            nxt.cur_mode = mmls_pkg::MODE_OPEN;
            nxt.reason   = mmls_pkg::RSN_NONE;
            nxt.deadline = sum;
          end
        end
      end
      mmls_pkg::CMD_CLOSED: begin
        if (state_i.locked || !tgt_closed || state_i.cur_mode != mmls_pkg::MODE_IDLE) begin
          ok = 1'b0;
        end else begin
          arm    = 1'b1;
          arm_ch = mmls_pkg::CHAN_BOTH;
          if (!item_i.arm_ok) begin
            stop     = 1'b1;
            stop_rsn = mmls_pkg::RSN_EMERG;
            ok       = 1'b0;
          end else begin
            dz           = 1'b1;
            nxt.cur_mode = item_i.target_mode;
            nxt.reason   = mmls_pkg::RSN_NONE;
            nxt.deadline = sum;
          end
        end
      end
      mmls_pkg::CMD_REFRESH: begin
        if (!tgt_closed || state_i.cur_mode != item_i.target_mode) begin
          ok = 1'b0;
        end else begin
          nxt.deadline = sum;
        end
      end
      mmls_pkg::CMD_REQUEST: begin
        stop = 1'b1;
        if (item_i.target_mode != mmls_pkg::MODE_IDLE) begin
          stop_rsn = mmls_pkg::RSN_HW;
          ok       = 1'b0;
        end
      end
      default: begin
        ok = 1'b0;
      end
    endcase

    // forced stop
    if (stop) begin
      nxt.cur_mode = mmls_pkg::MODE_IDLE;
      nxt.reason   = stop_rsn;
      nxt.deadline = 32'd0;
      dz           = 1'b1;
    end
  end

  assign state_o             = nxt;
  assign result_o.request_ok = ok;
  assign result_o.mode_now   = nxt.cur_mode;
  assign result_o.reason_now = nxt.reason;
  assign result_o.drive_zero = dz;
  assign result_o.motor_stop = stop;
  assign result_o.arm_strobe = arm;
  assign result_o.arm_channel = arm_ch;

endmodule

// ----- rtl/motor_mode_lease_supervisor_core.sv -----
`timescale 1ns / 1ps
// path: an accepted input word passes the input register, then the result register,
// before its result word is offered on the result stream
// throughput: one word per cycle while m_axis_tready_i does not stall the result stage
// the step logic is one short decode plus one 32-bit add and one 32-bit subtract between the two registers
// reset: asynchronous active low; mode safe idle, reason hw unverified, lock clear,
// deadline zero, open-loop max 2000 ms, lease 250 ms, both stages empty
// ----------------------------------------------------------------------------
// motor_mode_lease_supervisor_core
// drive mode supervisor with open-loop test window and closed-loop lease
// ----------------------------------------------------------------------------
module motor_mode_lease_supervisor_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [15:0] cfg_wdata_i,
  // command stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // now_ms[31:0], reset_lock[32], motor_select[34:33], test_len_ms[66:35],
  // target_mode[69:67], stop_reason[72:70], arm_ok[73], zero[79:74]
  input  logic [79:0] s_axis_tdata_i,
  // mode[2:0]
  input  logic [2:0]  s_axis_tuser_i,
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // request_ok[0], mode_now[3:1], reason_now[6:4], drive_zero[7], motor_stop[8],
  // arm_strobe[9], arm_channel[11:10], zero[15:12]
  output logic [15:0] m_axis_tdata_o
);

  mmls_pkg::cfg_t    cfg_q;
  mmls_pkg::state_t  state_q, state_d;
  mmls_pkg::item_t   in_q, in_d;
  mmls_pkg::result_t out_q, out_d;
  logic              in_valid_q;
  logic              out_valid_q;
  logic              advance;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.open_max <= mmls_pkg::OPEN_MAX_RST;
      cfg_q.lease    <= mmls_pkg::LEASE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        mmls_pkg::REG_OPEN_MAX: cfg_q.open_max <= cfg_wdata_i;
        mmls_pkg::REG_LEASE:    cfg_q.lease    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // handshake: input stage moves on whenever the result stage is free or drains
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  // unpack command word
  always_comb begin
    in_d.mode         = s_axis_tuser_i;
    in_d.now_ms       = s_axis_tdata_i[31:0];
    in_d.reset_lock   = s_axis_tdata_i[32];
    in_d.motor_select = s_axis_tdata_i[34:33];
    in_d.test_len_ms  = s_axis_tdata_i[66:35];
    in_d.target_mode  = s_axis_tdata_i[69:67];
    in_d.stop_reason  = s_axis_tdata_i[72:70];
    in_d.arm_ok       = s_axis_tdata_i[73];
  end

  // input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_q <= in_d;
    end
  end

  mmls_step u_step (
    .item_i   (in_q),
    .state_i  (state_q),
    .cfg_i    (cfg_q),
    .state_o  (state_d),
    .result_o (out_d)
  );

  // supervisor state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.cur_mode <= mmls_pkg::MODE_IDLE;
      state_q.reason   <= mmls_pkg::RSN_HW;
      state_q.locked   <= 1'b0;
      state_q.deadline <= 32'd0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  // pack result word
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'd0, out_q.arm_channel, out_q.arm_strobe, out_q.motor_stop,
                            out_q.drive_zero, out_q.reason_now, out_q.mode_now,
                            out_q.request_ok};

endmodule

// ----- rtl/mmls_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmls_checker
// port-level checks on the supervisor result stream
// ----------------------------------------------------------------------------
`include "motor_mode_lease_supervisor_core_assert.svh"

module mmls_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o
);

  logic       ok;
  logic [2:0] mode_now;
  logic [2:0] reason_now;
  logic       drive_zero;
  logic       motor_stop;
  logic       arm_strobe;
  logic [1:0] arm_channel;
  logic       in_idle;
  logic       out_held;
  logic       out_stop;
  logic       out_arm;
  logic       arm_pass;
  logic       arm_trip;

  assign ok          = m_axis_tdata_o[0];
  assign mode_now    = m_axis_tdata_o[3:1];
  assign reason_now  = m_axis_tdata_o[6:4];
  assign drive_zero  = m_axis_tdata_o[7];
  assign motor_stop  = m_axis_tdata_o[8];
  assign arm_strobe  = m_axis_tdata_o[9];
  assign arm_channel = m_axis_tdata_o[11:10];

  // qualified terms for the properties
  assign in_idle  = (mode_now == mmls_pkg::MODE_IDLE);
  assign out_held = m_axis_tvalid_o && !m_axis_tready_i;
  assign out_stop = m_axis_tvalid_o && motor_stop;
  assign out_arm  = m_axis_tvalid_o && arm_strobe;
  assign arm_pass = ok && !motor_stop && !in_idle;
  assign arm_trip = !ok && motor_stop && (reason_now == mmls_pkg::RSN_EMERG);

  // a stalled result word holds
  `MMLS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_held, m_axis_tvalid_o && $stable(m_axis_tdata_o))

  // a forced stop always lands in safe idle with the drive zeroed
  `MMLS_ASSERT_NOW(a_stop_idle, clk_i, rst_ni, out_stop, drive_zero && in_idle)

  // an arming attempt either enters a drive mode or trips an emergency stop
  `MMLS_ASSERT_NOW(a_arm_outcome, clk_i, rst_ni, out_arm, arm_pass || arm_trip)

  // no channel without an arming attempt
  `MMLS_ASSERT_NOW(a_arm_channel, clk_i, rst_ni, m_axis_tvalid_o && !arm_strobe, arm_channel == 2'd0)

  // the reported mode never lies above MODE_LINE
  `MMLS_ASSERT_NOW(a_mode_range, clk_i, rst_ni, m_axis_tvalid_o, mode_now <= mmls_pkg::MODE_LINE)

endmodule

bind motor_mode_lease_supervisor_core mmls_checker u_mmls_checker (.*);
